// ----- hw/rtl/rti_pkg.sv -----
package rti_pkg;

   localparam int ELEMENTS   = 128;
   localparam int POINTS     = 1024;
   localparam int EL_W       = $clog2(ELEMENTS);
   localparam int PT_W       = $clog2(POINTS);
   localparam int CNT_W      = PT_W + 1;
   localparam int ROW_AW     = EL_W + PT_W;
   localparam int ROWS       = ELEMENTS * POINTS;
   localparam int ROW_DW     = 64;
   localparam int PROD_W     = 65;
   localparam int MAG_W      = 33;
   localparam int ITER_W     = 7;
   localparam logic [ITER_W-1:0] MUL_STEPS = ITER_W'(MAG_W - 1);
   localparam logic [ITER_W-1:0] DIV_STEPS = ITER_W'(PROD_W - 1);

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NODATA = 2'd1;
   localparam logic [1:0] ST_BELOW  = 2'd2;
   localparam logic [1:0] ST_SAT    = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [6:0]  element;
      logic [9:0]  point_index;
      logic        last_point;
      logic [31:0] radius;
      logic signed [31:0] charge;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] potential;
      logic [1:0]  status;
   } rsp_item_type;

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_CNT  = 12'b0000_0000_0010,
      S_LCHK = 12'b0000_0000_0100,
      S_SRD  = 12'b0000_0000_1000,
      S_SCHK = 12'b0000_0001_0000,
      S_MUL  = 12'b0000_0010_0000,
      S_DIV  = 12'b0000_0100_0000,
      S_INTP = 12'b0000_1000_0000,
      S_PREP = 12'b0001_0000_0000,
      S_FIN  = 12'b0010_0000_0000,
      S_DONE = 12'b0100_0000_0000,
      S_ASYM = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic       take;
      logic       rd_last;
      logic       rd_row;
      logic       clr_row;
      logic       inc_row;
      logic       set_prev;
      logic       start_mul;
      logic       step_mul;
      logic       div_go;
      logic       start_asym;
      logic       start_pot;
      logic       step_div;
      logic       p_from_n0;
      logic       p_from_quo;
      logic       set_res;
      logic [1:0] res_code;
      logic       set_res_div;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic req_load;
      logic cnt_zero;
      logic rad_zero;
      logic beyond;
      logic one_row;
      logic first_row;
      logic hit;
      logic flat;
      logic last_pair;
      logic iter_done;
      logic div_interp;
   } stat_type;

endpackage

// ----- hw/rtl/rti_ram.sv -----
module rti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- hw/rtl/rti_datapath.sv -----
module rti_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  rti_pkg::cmd_type      cmd,
   output rti_pkg::stat_type     stat,
   input  rti_pkg::req_item_type req_item,
   output rti_pkg::rsp_item_type rsp_item
);
   import rti_pkg::*;

   logic [EL_W-1:0]     el_ff;
   logic [31:0]         r_ff;
   logic [CNT_W-1:0]    n_ff, count_now;
   logic [PT_W-1:0]     row_ff, row_in;
   logic [31:0]         prev_r_ff;
   logic signed [31:0]  prev_n_ff;
   logic [31:0]         den_ff;
   logic [MAG_W-1:0]    mb_ff;
   logic [31:0]         ma_ff;
   logic [PROD_W-1:0]   dv_ff, dv_in;
   logic [31:0]         rem_ff, rem_in;
   logic [ITER_W-1:0]   it_ff;
   logic                neg_ff, interp_ff;
   logic signed [31:0]  p_ff;
   logic signed [31:0]  res_pot_ff;
   logic [1:0]          res_st_ff;
   rsp_item_type        rsp_ff;
   logic [ELEMENTS-1:0] vld_ff;
   logic                vld_rd_ff;

   logic                row_we, cnt_we;
   logic [ROW_AW-1:0]   row_raddr;
   logic [ROW_DW-1:0]   row_rdata;
   logic [CNT_W-1:0]    cnt_rdata;
   logic [31:0]         rd_r;
   logic signed [31:0]  rd_n;
   logic signed [32:0]  dn;
   logic [MAG_W-1:0]    dn_mag;
   logic [32:0]         trial;
   logic                ge;
   logic signed [33:0]  p_sum;
   logic [31:0]         p_abs;

   assign row_we = cmd.take && (req_item.mode == MODE_LOAD);
   assign cnt_we = row_we && req_item.last_point;

   assign count_now = vld_rd_ff ? cnt_rdata : '0;
   assign row_in    = count_now[PT_W-1:0] - PT_W'(1);
   assign row_raddr = cmd.rd_last ? {el_ff, row_in} : {el_ff, row_ff};

   rti_ram #(.WIDTH(ROW_DW), .DEPTH(ROWS)) u_rows (
      .clock (clock),
      .we    (row_we),
      .waddr ({req_item.element, req_item.point_index}),
      .wdata ({req_item.radius, req_item.charge}),
      .raddr (row_raddr),
      .rdata (row_rdata)
   );

   rti_ram #(.WIDTH(CNT_W), .DEPTH(ELEMENTS)) u_counts (
      .clock (clock),
      .we    (cnt_we),
      .waddr (req_item.element),
      .wdata ({1'b0, req_item.point_index} + CNT_W'(1)),
      .raddr (req_item.element),
      .rdata (cnt_rdata)
   );

   assign rd_r   = row_rdata[63:32];
   assign rd_n   = row_rdata[31:0];
   assign dn     = 33'(rd_n) - 33'(prev_n_ff);
   assign dn_mag = dn[32] ? MAG_W'(-dn) : MAG_W'(dn);

   // one restoring division step
   assign trial  = {rem_ff, dv_ff[PROD_W-1]};
   assign ge     = trial >= {1'b0, den_ff};
   assign rem_in = ge ? 32'(trial - {1'b0, den_ff}) : trial[31:0];

   assign p_sum = neg_ff ? 34'(prev_n_ff) - 34'(dv_ff[MAG_W-1:0])
                         : 34'(prev_n_ff) + 34'(dv_ff[MAG_W-1:0]);
   assign p_abs = p_ff[31] ? 32'(-p_ff) : 32'(p_ff);

   always_comb begin
      dv_in = dv_ff;
      priority if (cmd.start_mul) begin
         dv_in = '0;
      end else if (cmd.step_mul) begin
         dv_in = PROD_W'({dv_ff[PROD_W-2:0], 1'b0}) +
                 (mb_ff[MAG_W-1] ? PROD_W'(ma_ff) : '0);
      end else if (cmd.start_asym) begin
         dv_in = PROD_W'({el_ff, 44'b0});
      end else if (cmd.start_pot) begin
         dv_in = PROD_W'({p_abs, 20'b0});
      end else if (cmd.step_div) begin
         dv_in = {dv_ff[PROD_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cnt_we) begin
         vld_ff[req_item.element] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      dv_ff <= dv_in;
      if (cmd.take) begin
         el_ff     <= req_item.element;
         r_ff      <= req_item.radius;
         vld_rd_ff <= vld_ff[req_item.element];
      end
      if (cmd.rd_last) n_ff <= count_now;
      if (cmd.clr_row) row_ff <= '0;
      else if (cmd.inc_row) row_ff <= row_ff + PT_W'(1);
      if (cmd.set_prev) begin
         prev_r_ff <= rd_r;
         prev_n_ff <= rd_n;
      end
      if (cmd.start_mul) begin
         ma_ff     <= r_ff - prev_r_ff;
         mb_ff     <= dn_mag;
         neg_ff    <= dn[32];
         den_ff    <= rd_r - prev_r_ff;
         interp_ff <= 1'b1;
      end else if (cmd.step_mul) begin
         mb_ff <= {mb_ff[MAG_W-2:0], 1'b0};
      end
      // load the step counter for a new pass, else count it down
      if (cmd.start_mul) begin
         it_ff <= MUL_STEPS;
      end else if (cmd.div_go || cmd.start_asym || cmd.start_pot) begin
         it_ff <= DIV_STEPS;
      end else if (cmd.step_mul || cmd.step_div) begin
         it_ff <= it_ff - ITER_W'(1);
      end
      if (cmd.div_go) begin
         rem_ff <= '0;
      end
      if (cmd.start_asym || cmd.start_pot) begin
         rem_ff    <= '0;
         den_ff    <= r_ff;
         interp_ff <= 1'b0;
         neg_ff    <= cmd.start_pot ? p_ff[31] : 1'b0;
      end
      if (cmd.step_div) begin
         rem_ff <= rem_in;
      end
      if (cmd.p_from_n0) p_ff <= prev_n_ff;
      else if (cmd.p_from_quo) p_ff <= p_sum[31:0];
      if (cmd.set_res) begin
         res_pot_ff <= '0;
         res_st_ff  <= cmd.res_code;
      end else if (cmd.set_res_div) begin
         // saturate the signed quotient to 32 bits
         if (neg_ff) begin
            if (dv_ff > PROD_W'(33'h0_8000_0000)) begin
               res_pot_ff <= 32'sh8000_0000;
               res_st_ff  <= ST_SAT;
            end else begin
               res_pot_ff <= 32'(-dv_ff[31:0]);
               res_st_ff  <= ST_OK;
            end
         end else begin
            if (dv_ff > PROD_W'(32'h7FFF_FFFF)) begin
               res_pot_ff <= 32'sh7FFF_FFFF;
               res_st_ff  <= ST_SAT;
            end else begin
               res_pot_ff <= dv_ff[31:0];
               res_st_ff  <= ST_OK;
            end
         end
      end
      if (cmd.load_rsp) begin
         rsp_ff.potential <= res_pot_ff;
         rsp_ff.status    <= res_st_ff;
      end
   end

   assign stat.req_load   = req_item.mode == MODE_LOAD;
   assign stat.cnt_zero   = count_now == '0;
   assign stat.rad_zero   = r_ff == '0;
   assign stat.beyond     = r_ff >= rd_r;
   assign stat.one_row    = n_ff == CNT_W'(1);
   assign stat.first_row  = row_ff == '0;
   assign stat.hit        = (r_ff >= prev_r_ff) && (r_ff <= rd_r);
   assign stat.flat       = rd_r == prev_r_ff;
   assign stat.last_pair  = ({1'b0, row_ff} + CNT_W'(1)) == n_ff;
   assign stat.iter_done  = it_ff == '0;
   assign stat.div_interp = interp_ff;

   assign rsp_item = rsp_ff;
endmodule

// ----- hw/rtl/rti_ctrl.sv -----
module rti_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  rti_pkg::stat_type stat,
   output rti_pkg::cmd_type  cmd
);
   import rti_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (stat.req_load) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = ST_OK;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_CNT;
               end
            end
         end
         S_CNT: begin
            cmd.rd_last = 1'b1;
            if (stat.cnt_zero) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_NODATA;
               state_in     = S_DONE;
            end else if (stat.rad_zero) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_OK;
               state_in     = S_DONE;
            end else begin
               state_in = S_LCHK;
            end
         end
         S_LCHK: begin
            if (stat.beyond) begin
               state_in = S_ASYM;
            end else if (stat.one_row) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_BELOW;
               state_in     = S_DONE;
            end else begin
               cmd.clr_row = 1'b1;
               state_in    = S_SRD;
            end
         end
         S_ASYM: begin
            cmd.start_asym = 1'b1;
            state_in       = S_DIV;
         end
         S_SRD: begin
            cmd.rd_row = 1'b1;
            state_in   = S_SCHK;
         end
         S_SCHK: begin
            if (stat.first_row) begin
               cmd.set_prev = 1'b1;
               cmd.inc_row  = 1'b1;
               state_in     = S_SRD;
            end else if (stat.hit) begin
               if (stat.flat) begin
                  cmd.p_from_n0 = 1'b1;
                  state_in      = S_PREP;
               end else begin
                  cmd.start_mul = 1'b1;
                  state_in      = S_MUL;
               end
            end else if (stat.last_pair) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_BELOW;
               state_in     = S_DONE;
            end else begin
               cmd.set_prev = 1'b1;
               cmd.inc_row  = 1'b1;
               state_in     = S_SRD;
            end
         end
         S_MUL: begin
            cmd.step_mul = 1'b1;
            if (stat.iter_done) begin
               cmd.div_go = 1'b1;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            cmd.step_div = 1'b1;
            if (stat.iter_done) begin
               state_in = stat.div_interp ? S_INTP : S_FIN;
            end
         end
         S_INTP: begin
            cmd.p_from_quo = 1'b1;
            state_in       = S_PREP;
         end
         S_PREP: begin
            cmd.start_pot = 1'b1;
            state_in      = S_DIV;
         end
         S_FIN: begin
            cmd.set_res_div = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");
   a_done_shows_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && slot_free) |=> (rsp_valid && state_ff == S_IDLE))
      else $error("finished item not presented");
   a_mul_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && stat.iter_done) |=> (state_ff == S_DIV))
      else $error("product not handed to divider");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> slot_free)
      else $error("result register overwritten");
`endif
endmodule

// ----- hw/rtl/radial_table_interpolator.sv -----
// Radial table interpolator.
// req_ channel (valid/ready): mode 0 loads one table row (radius, charge) of
// an element; last_point sets that element's row count to point_index + 1.
// Mode 1 queries: the first interval holding the radius is found, the charge
// is interpolated and divided by the radius, giving a Q12.20 potential.
// At or beyond the last breakpoint the result is (element << 44) / radius.
// rsp_ channel (valid/ready): one item per request, potential and status.
// A query runs a linear scan over the table rows, then, for an interval that
// is not flat, a shift-add multiply, and one or two restoring divisions; its
// worst case is set by the single row memory read port and the
// one-bit-a-cycle divider. One item is worked on at a time.
// The result sits in an output register; a new item is accepted while it
// waits, and the block holds in its final state if the receiver stalls.
// Reset clears the row counts (no element has data) and the handshake
// state; table rows are undefined until loaded.
module radial_table_interpolator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rti_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rti_pkg::rsp_item_type rsp_item
);
   import rti_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence the query: count check, last-row check, scan, multiply, divide
   rti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold tables, operands, the shared shift-add/restoring unit, result
   rti_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );
endmodule

// ----- tb/tb_radial_table_interpolator.sv -----
module tb_radial_table_interpolator;
   import rti_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int ITEM_TARGET  = 400;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      req_item_type it;
      bit           typed;
      rsp_item_type rsp;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;

   // shadow copy of the tables, as seen by the stimulus generator
   logic [31:0]  shadow_radius [int];
   logic [31:0]  shadow_charge [int];
   int           shadow_count [ELEMENTS];

   req_item_type stim_q [$];
   rsp_item_type pending_q [$];
   rsp_item_type potential_q [$];

   int           cycle_count;
   int           accepted;
   int           errors;
   bit           stim_done;

   radial_table_interpolator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Divide a signed numerator by a non-zero radius, truncating toward zero,
   // and clip to the signed 32-bit range.
   function automatic rsp_item_type divide_clip(longint num, longint unsigned den);
      rsp_item_type   res;
      longint unsigned mag;
      longint unsigned quo;
      res = '0;
      mag = (num < 0) ? longint'(-num) : num;
      quo = mag / den;
      if (num < 0) begin
         if (quo > 64'h8000_0000) begin
            res.potential = 32'h8000_0000;
            res.status    = ST_SAT;
         end else begin
            res.potential = 32'(0 - quo);
         end
      end else if (quo > 64'h7FFF_FFFF) begin
         res.potential = 32'h7FFF_FFFF;
         res.status    = ST_SAT;
      end else begin
         res.potential = 32'(quo);
      end
      return res;
   endfunction

   // Apply one item to the shadow tables and return the potential it yields.
   function automatic rsp_item_type predict_potential(req_item_type it);
      rsp_item_type    res;
      int              base;
      int              n;
      longint unsigned r, r0, r1, mag, corr;
      longint          n0, n1, dn, p;
      bit              found;
      res = '0;
      base = int'(it.element) * POINTS;
      r = it.radius;
      if (it.mode == MODE_LOAD) begin
         shadow_radius[base + it.point_index] = it.radius;
         shadow_charge[base + it.point_index] = it.charge;
         if (it.last_point) shadow_count[it.element] = int'(it.point_index) + 1;
      end else if (shadow_count[it.element] == 0) begin
         res.status = ST_NODATA;
      end else if (r != 0) begin
         n = shadow_count[it.element];
         if (r >= shadow_radius[base + n - 1]) begin
            res = divide_clip(longint'(it.element) <<< 44, r);
         end else begin
            found = 1'b0;
            for (int i = 0; i + 1 < n && !found; i++) begin
               r0 = shadow_radius[base + i];
               r1 = shadow_radius[base + i + 1];
               if (r >= r0 && r <= r1) begin
                  n0 = longint'($signed(shadow_charge[base + i]));
                  n1 = longint'($signed(shadow_charge[base + i + 1]));
                  p = n0;
                  if (r1 != r0) begin
                     dn = n1 - n0;
                     mag = (dn < 0) ? longint'(-dn) : dn;
                     corr = ((r - r0) * mag) / (r1 - r0);
                     p = (dn < 0) ? n0 - longint'(corr) : n0 + longint'(corr);
                  end
                  res = divide_clip(p * 1048576, r);
                  found = 1'b1;
               end
            end
            if (!found) res.status = ST_BELOW;
         end
      end
      return res;
   endfunction

   function automatic stim_row_type stim_row(logic mode, int el, int idx, logic last,
                                             logic [31:0] rad, logic [31:0] chg,
                                             bit typed, logic [31:0] pot, logic [1:0] st);
      stim_row_type s;
      s.it.mode        = mode;
      s.it.element     = 7'(el);
      s.it.point_index = 10'(idx);
      s.it.last_point  = last;
      s.it.radius      = rad;
      s.it.charge      = chg;
      s.typed          = typed;
      s.rsp.potential  = pot;
      s.rsp.status     = st;
      return s;
   endfunction

   // Queue one item; a typed expectation overrides the predictor.
   task automatic queue_item(req_item_type it, bit typed, rsp_item_type rsp);
      rsp_item_type pred;
      pred = predict_potential(it);
      stim_q.push_back(it);
      pending_q.push_back(typed ? rsp : pred);
   endtask

   task automatic queue_plain(req_item_type it);
      queue_item(it, 1'b0, '0);
   endtask

   function automatic logic [31:0] rand_charge();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         1:       return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic bit rows_written(int el, int idx);
      for (int i = 0; i <= idx; i++)
         if (!shadow_radius.exists(el * POINTS + i)) return 1'b0;
      return 1'b1;
   endfunction

   // Load a whole table in order, then query it a few times.
   task automatic queue_table_and_queries();
      req_item_type it;
      logic [31:0]  radii [$];
      int           n, sh, el, nq;
      logic [31:0]  lo, hi;
      el = $urandom_range(0, ELEMENTS - 1);
      n = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      sh = $urandom_range(4, 32);
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(0, 7) == 0) radii.push_back(radii[i - 1]);
         else radii.push_back(sh == 32 ? $urandom : ($urandom & ((32'd1 << sh) - 1)) | 32'd1);
      end
      // an unsorted table now and then
      if ($urandom_range(0, 9) != 0) radii.sort();
      for (int i = 0; i < n; i++) begin
         it.mode        = MODE_LOAD;
         it.element     = 7'(el);
         it.point_index = 10'(i);
         it.last_point  = (i == n - 1);
         it.radius      = radii[i];
         it.charge      = rand_charge();
         queue_plain(it);
      end
      nq = $urandom_range(2, 6);
      for (int k = 0; k < nq; k++) begin
         it = '0;
         it.mode    = MODE_QUERY;
         it.element = 7'(el);
         it.charge  = $urandom;
         it.point_index = 10'($urandom);
         it.last_point  = 1'($urandom);
         lo = radii[$urandom_range(0, n - 1)];
         hi = radii[$urandom_range(0, n - 1)];
         case ($urandom_range(0, 9))
            0:       it.radius = 32'd0;
            1:       it.radius = lo;
            2:       it.radius = radii[0] == 0 ? 32'd0 : $urandom_range(0, radii[0] - 1);
            3:       it.radius = $urandom_range(radii[n - 1], 32'hFFFF_FFFF);
            4:       it.radius = $urandom;
            default: it.radius = (lo < hi) ? $urandom_range(lo, hi) : $urandom_range(hi, lo);
         endcase
         queue_plain(it);
      end
   endtask

   // Stray loads and queries on any element.
   task automatic queue_noise();
      req_item_type it;
      it.mode        = 1'($urandom);
      it.element     = 7'($urandom);
      it.point_index = ($urandom_range(0, 1) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
      it.radius      = $urandom;
      it.charge      = rand_charge();
      it.last_point  = 1'($urandom);
      if (it.mode == MODE_LOAD && it.last_point) begin
         // drop the row count only onto rows that are all loaded
         shadow_radius[int'(it.element) * POINTS + it.point_index] = it.radius;
         it.last_point = rows_written(int'(it.element), int'(it.point_index));
      end
      queue_plain(it);
   endtask

   task automatic build_stimulus();
      stim_row_type directed [$];
      directed = '{
         stim_row(MODE_QUERY, 5, 0, 0, 32'd1, 0, 1, 0, ST_NODATA),
         stim_row(MODE_LOAD, 5, 0, 0, 32'h0100_0000, 32'h0100_0000, 1, 0, ST_OK),
         stim_row(MODE_LOAD, 5, 1, 0, 32'h0200_0000, 32'h0300_0000, 1, 0, ST_OK),
         stim_row(MODE_LOAD, 5, 2, 0, 32'h0200_0000, 32'h7FFF_FFFF, 1, 0, ST_OK),
         stim_row(MODE_LOAD, 5, 3, 1, 32'h0400_0000, 32'h8000_0000, 1, 0, ST_OK),
         stim_row(MODE_QUERY, 5, 0, 0, 32'd0, 0, 1, 0, ST_OK),
         stim_row(MODE_QUERY, 5, 0, 0, 32'h0080_0000, 0, 1, 0, ST_BELOW),
         stim_row(MODE_QUERY, 5, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, ST_OK),
         stim_row(MODE_QUERY, 5, 0, 0, 32'h0180_0000, 0, 0, 0, ST_OK),
         stim_row(MODE_QUERY, 5, 0, 0, 32'h0200_0000, 0, 0, 0, ST_OK),
         stim_row(MODE_QUERY, 5, 0, 0, 32'h0300_0000, 0, 0, 0, ST_OK),
         stim_row(MODE_QUERY, 5, 1023, 1, 32'h0400_0000, 32'hFFFF_FFFF, 0, 0, ST_OK),
         stim_row(MODE_LOAD, 127, 0, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 0, ST_OK),
         stim_row(MODE_QUERY, 127, 0, 0, 32'd1, 0, 1, 0, ST_BELOW),
         stim_row(MODE_QUERY, 127, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, ST_OK),
         stim_row(MODE_LOAD, 0, 0, 0, 32'd1, 32'h8000_0000, 1, 0, ST_OK),
         stim_row(MODE_LOAD, 0, 1, 1, 32'd2, 32'h7FFF_FFFF, 1, 0, ST_OK),
         stim_row(MODE_QUERY, 0, 0, 0, 32'd1, 0, 1, 32'h8000_0000, ST_SAT),
         stim_row(MODE_QUERY, 0, 0, 0, 32'd2, 0, 1, 0, ST_OK),
         stim_row(MODE_QUERY, 127, 0, 0, 32'd1 << 20, 0, 1, 0, ST_BELOW),
         stim_row(MODE_LOAD, 9, 1023, 0, 32'h1234_5678, 32'h8765_4321, 1, 0, ST_OK),
         stim_row(MODE_QUERY, 9, 0, 0, 32'd7, 0, 1, 0, ST_NODATA)
      };
      foreach (directed[i]) queue_item(directed[i].it, directed[i].typed, directed[i].rsp);
      while (stim_q.size() < ITEM_TARGET) begin
         if ($urandom_range(0, 3) != 0) queue_table_and_queries();
         else queue_noise();
      end
   endtask

   // Quiet window: no idling on either side for a long stretch.
   function automatic bit idle_now();
      if (accepted >= 150 && accepted < 250) return 1'b0;
      return $urandom_range(0, 99) < 21;
   endfunction

   // Request side: present the next item, hold it until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_item  <= '0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            potential_q.push_back(pending_q.pop_front());
            accepted++;
         end
         if (stim_q.size() != 0 && !idle_now()) begin
            req_valid <= 1'b1;
            req_item  <= stim_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: stall at random, compare each accepted item.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (potential_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected item: potential %h status %0d",
                           rsp_item.potential, rsp_item.status);
            end else begin
               if (rsp_item.potential !== potential_q[0].potential ||
                   rsp_item.status !== potential_q[0].status) begin
                  errors++;
                  if (errors <= 10)
                     $display("item %0d: expected potential %h status %0d, got %h status %0d",
                              accepted - potential_q.size(), potential_q[0].potential,
                              potential_q[0].status, rsp_item.potential, rsp_item.status);
               end
               void'(potential_q.pop_front());
            end
         end
         rsp_ready <= !idle_now();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("radial_table_interpolator: mismatch");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_item    = '0;
      rsp_ready   = 1'b0;
      cycle_count = 0;
      accepted    = 0;
      errors      = 0;
      foreach (shadow_count[i]) shadow_count[i] = 0;
      build_stimulus();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // hold until every item is in and every result is out
      while (stim_q.size() != 0 || req_valid || potential_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (potential_q.size() != 0) errors++;
      if (errors == 0) begin
         $display("radial_table_interpolator: match");
      end else begin
         $display("radial_table_interpolator: mismatch");
      end
      $finish;
   end

endmodule
